@@ rtl/psched_pkg.sv @@
// ----------------------------------------------------------------------------
// psched_pkg
// Shared widths, status codes and controller/datapath interface types for the
// preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 24;
    localparam int ID_W    = 5;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = 40;   // arrival, burst, priority
    localparam int S_TUSER_W = 1;    // req_type
    localparam int M_TDATA_W = 104;  // task_id, completion, turnaround, waiting, now, pad
    localparam int M_TUSER_W = 3;    // status, finished

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [STAT_W-1:0] ST_LOADED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RAN    = 2'd2;
    localparam logic [STAT_W-1:0] ST_IDLE   = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic capture;    // input transfer taken this cycle
        logic load;       // append the captured task
        logic scan_step;  // issue the next table read of the scan
        logic update;     // apply the tick: time, remaining, first results
        logic finish;     // settle waiting time and clear unused fields
        logic emit;       // move the result into the output register
    } psched_cmd_t;

    typedef struct packed {
        logic scan_done;  // every loaded slot has been compared
        logic out_free;   // output register can take a result this cycle
    } psched_sts_t;

endpackage

@@ rtl/psched_ram.sv @@
// ----------------------------------------------------------------------------
// psched_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psched_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ rtl/psched_ctrl.sv @@
// ----------------------------------------------------------------------------
// psched_ctrl
// Request sequencer: takes one request, walks it through load or scan, update and finish,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module psched_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   req_type,
    input  psched_pkg::psched_sts_t sts,
    output psched_pkg::psched_cmd_t cmd
);
    import psched_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.capture   = s_tvalid && s_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (req_type == REQ_TICK) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = S_EMIT;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hold until the previous result has been taken
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/psched_dp.sv @@
// ----------------------------------------------------------------------------
// psched_dp
// Scheduler datapath: task tables, scan comparator, time counter, result
// arithmetic and output register.
// ----------------------------------------------------------------------------
module psched_dp #(
    parameter int MAX_TASKS = psched_pkg::MAX_TASKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [psched_pkg::S_TDATA_W-1:0]    s_tdata,
    input  psched_pkg::psched_cmd_t             cmd,
    output psched_pkg::psched_sts_t             sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [psched_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [psched_pkg::M_TUSER_W-1:0]    m_tuser
);
    import psched_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int ST_W  = ARR_W + BURST_W + PRIO_W;

    // captured load fields
    logic [ARR_W-1:0]   arr_in_reg;
    logic [BURST_W-1:0] burst_in_reg;
    logic [PRIO_W-1:0]  prio_in_reg;

    logic [CNT_W-1:0]  task_count_reg, task_count_next;
    logic [TIME_W-1:0] tick_time_reg, tick_time_next;
    logic [TIME_W-1:0] tick_sat;

    // scan pipeline
    logic [CNT_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_valid_reg, rd_valid_next;
    logic             issue;

    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [ARR_W-1:0]   best_arr_reg;
    logic [BURST_W-1:0] best_burst_reg;
    logic [BURST_W-1:0] best_rem_reg;
    logic [PRIO_W-1:0]  best_pr_reg;

    // table ports
    logic [ST_W-1:0]    st_rdata;
    logic [BURST_W-1:0] rem_rdata;
    logic [ARR_W-1:0]   rd_arr;
    logic [BURST_W-1:0] rd_burst;
    logic [PRIO_W-1:0]  rd_pr;
    logic               cand;
    logic               full;
    logic               rem_we;
    logic [IDX_W-1:0]   rem_waddr;
    logic [BURST_W-1:0] rem_wdata;

    // result staging
    logic [STAT_W-1:0] res_status_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic              res_fin_reg;
    logic [TIME_W-1:0] res_ct_reg, res_tat_reg, res_wt_reg, res_now_reg;
    logic [TIME_W-1:0] tat_calc, wt_calc;

    logic m_tvalid_reg, m_tvalid_next;

    assign full  = (task_count_reg == CNT_W'(MAX_TASKS));
    assign issue = cmd.scan_step && (scan_idx_reg != task_count_reg);

    assign rd_arr   = st_rdata[ARR_W-1:0];
    assign rd_burst = st_rdata[ARR_W+BURST_W-1:ARR_W];
    assign rd_pr    = st_rdata[ST_W-1:ARR_W+BURST_W];

    assign cand = rd_valid_reg
               && (TIME_W'(rd_arr) <= tick_time_reg)
               && (rem_rdata != '0)
               && (!found_reg || (rd_pr < best_pr_reg));

    assign sts.scan_done = (scan_idx_reg == task_count_reg) && !rd_valid_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign rem_we    = (cmd.load && !full) || (cmd.update && found_reg);
    assign rem_waddr = cmd.load ? task_count_reg[IDX_W-1:0] : best_idx_reg;
    assign rem_wdata = cmd.load ? burst_in_reg : (best_rem_reg - BURST_W'(1));

    psched_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_static_ram (
        .aclk  (aclk),
        .we    (cmd.load && !full),
        .waddr (task_count_reg[IDX_W-1:0]),
        .wdata ({prio_in_reg, burst_in_reg, arr_in_reg}),
        .re    (issue),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (st_rdata)
    );

    psched_ram #(
        .WIDTH (BURST_W),
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_rem_ram (
        .aclk  (aclk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .re    (issue),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rem_rdata)
    );

    assign tick_sat = (tick_time_reg == TIME_MAX) ? tick_time_reg
                                                  : (tick_time_reg + TIME_W'(1));

    assign tat_calc = (tick_sat >= TIME_W'(best_arr_reg))
                    ? (tick_sat - TIME_W'(best_arr_reg)) : '0;
    assign wt_calc  = (res_tat_reg >= TIME_W'(best_burst_reg))
                    ? (res_tat_reg - TIME_W'(best_burst_reg)) : '0;

    always_comb begin
        task_count_next = task_count_reg;
        tick_time_next  = tick_time_reg;
        rd_valid_next   = issue;
        m_tvalid_next   = m_tvalid_reg;
        if (cmd.load && !full) begin
            task_count_next = task_count_reg + CNT_W'(1);
        end
        if (cmd.update) begin
            tick_time_next = tick_sat;
        end
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
            tick_time_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            task_count_reg <= task_count_next;
            tick_time_reg  <= tick_time_next;
            rd_valid_reg   <= rd_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // capture, scan and best-candidate tracking
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            arr_in_reg   <= s_tdata[ARR_W-1:0];
            burst_in_reg <= s_tdata[ARR_W+BURST_W-1:ARR_W];
            prio_in_reg  <= s_tdata[ST_W-1:ARR_W+BURST_W];
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else begin
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                rd_idx_reg   <= scan_idx_reg[IDX_W-1:0];
            end
            if (cand) begin
                found_reg      <= 1'b1;
                best_idx_reg   <= rd_idx_reg;
                best_arr_reg   <= rd_arr;
                best_burst_reg <= rd_burst;
                best_rem_reg   <= rem_rdata;
                best_pr_reg    <= rd_pr;
            end
        end
    end

    // result staging
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_fin_reg <= 1'b0;
            res_ct_reg  <= '0;
            res_tat_reg <= '0;
            res_wt_reg  <= '0;
            res_now_reg <= tick_time_reg;
            if (full) begin
                res_status_reg <= ST_FULL;
                res_id_reg     <= '0;
            end else begin
                res_status_reg <= ST_LOADED;
                res_id_reg     <= ID_W'({1'b0, task_count_reg} + (CNT_W+1)'(1));
            end
        end
        if (cmd.update) begin
            res_now_reg <= tick_time_reg;
            res_ct_reg  <= tick_sat;
            res_tat_reg <= tat_calc;
            if (found_reg) begin
                res_status_reg <= ST_RAN;
                res_id_reg     <= ID_W'({1'b0, best_idx_reg} + (IDX_W+1)'(1));
                res_fin_reg    <= (best_rem_reg == BURST_W'(1));
            end else begin
                res_status_reg <= ST_IDLE;
                res_id_reg     <= '0;
                res_fin_reg    <= 1'b0;
            end
        end
        if (cmd.finish) begin
            if (res_fin_reg) begin
                res_wt_reg <= wt_calc;
            end else begin
                res_ct_reg  <= '0;
                res_tat_reg <= '0;
                res_wt_reg  <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata <= {{(M_TDATA_W-ID_W-4*TIME_W){1'b0}}, res_now_reg, res_wt_reg,
                        res_tat_reg, res_ct_reg, res_id_reg};
            m_tuser <= {res_fin_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        task_count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table depth");

    a_time_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> tick_time_reg >= $past(tick_time_reg))
        else $error("time counter went backwards");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result overwrote an untaken transfer");

    a_fin_ran: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser[M_TUSER_W-1] |-> m_tuser[STAT_W-1:0] == ST_RAN)
        else $error("finished flag on a result where no task ran");

endmodule

@@ rtl/preemptive_priority_scheduler.sv @@
// Load request: the table write, then the move of the result to the output register.
// Tick request: the scan reads one slot a cycle and then closes the scan;
//   update, finish and output follow in turn.
// One request is in flight at a time; a new one is taken while the last result waits.
// Reset (aresetn low, synchronous) empties the table and clears the time counter;
//   table contents are not cleared and are only read once loaded.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Tick-driven preemptive priority scheduler over a table of loaded tasks.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
    parameter int MAX_TASKS = psched_pkg::MAX_TASKS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // arrival[15:0], burst[31:16], priority_req[39:32]
    input  logic [psched_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic [psched_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // task_id[4:0], completion_time[28:5], turnaround[52:29], waiting[76:53],
    // now[100:77], zero[103:101]
    output logic [psched_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0], finished[2]
    output logic [psched_pkg::M_TUSER_W-1:0]  m_tuser
);
    import psched_pkg::*;

    psched_cmd_t cmd;
    psched_sts_t sts;

    psched_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    psched_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ sim/tb_preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler
// Streams load and tick requests into the scheduler with random gaps and
// random result back-pressure. A built-in copy of the task table predicts
// every result, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;

    import psched_pkg::*;

    localparam int TASK_SLOTS   = MAX_TASKS_DEF;
    localparam int RANDOM_ITEMS = 650;

    typedef struct packed {
        logic               req;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } sched_request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   task_id;
        logic              finished;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] now;
    } sched_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // scheduler state as the testbench sees it
    logic [ARR_W-1:0]   slot_arrival   [TASK_SLOTS];
    logic [BURST_W-1:0] slot_burst     [TASK_SLOTS];
    logic [BURST_W-1:0] slot_remaining [TASK_SLOTS];
    logic [PRIO_W-1:0]  slot_prio      [TASK_SLOTS];
    int                 loaded_tasks = 0;
    logic [TIME_W-1:0]  tick_count   = '0;

    sched_request_t pending_requests[$];
    sched_result_t  expected_results[$];
    sched_request_t cur_req;
    sched_result_t  want;

    int total_items    = 0;
    int accepted_count = 0;
    int ticks_queued   = 0;
    int fail_count     = 0;
    int send_wait      = 0;
    int send_calm      = 0;
    int recv_stall     = 0;
    int recv_calm      = 0;

    preemptive_priority_scheduler i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic sched_result_t schedule_step(input sched_request_t r);
        sched_result_t res;
        logic          found;
        int            pick;
        logic [PRIO_W-1:0] pick_prio;
        logic [TIME_W-1:0] tat;
        res      = '0;
        res.now  = tick_count;
        found    = 1'b0;
        pick     = 0;
        pick_prio = '0;
        if (r.req == REQ_LOAD) begin
            if (loaded_tasks >= TASK_SLOTS) begin
                res.status = ST_FULL;
            end else begin
                slot_arrival[loaded_tasks]   = r.arrival;
                slot_burst[loaded_tasks]     = r.burst;
                slot_remaining[loaded_tasks] = r.burst;
                slot_prio[loaded_tasks]      = r.prio;
                loaded_tasks++;
                res.status  = ST_LOADED;
                res.task_id = ID_W'(loaded_tasks);
            end
            return res;
        end
        for (int i = 0; i < loaded_tasks; i++) begin
            if (TIME_W'(slot_arrival[i]) <= tick_count && slot_remaining[i] != 0 &&
                (!found || slot_prio[i] < pick_prio)) begin
                found     = 1'b1;
                pick      = i;
                pick_prio = slot_prio[i];
            end
        end
        // the time counter sticks at its top value
        if (tick_count != TIME_MAX)
            tick_count = tick_count + TIME_W'(1);
        if (!found) begin
            res.status = ST_IDLE;
            return res;
        end
        slot_remaining[pick] = slot_remaining[pick] - BURST_W'(1);
        res.status  = ST_RAN;
        res.task_id = ID_W'(pick + 1);
        if (slot_remaining[pick] == 0) begin
            tat = tick_count - TIME_W'(slot_arrival[pick]);
            res.finished   = 1'b1;
            res.completion = tick_count;
            res.turnaround = tat;
            res.waiting    = (tat >= TIME_W'(slot_burst[pick])) ?
                             tat - TIME_W'(slot_burst[pick]) : '0;
        end
        return res;
    endfunction

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        // now and then run a stretch without any idling
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic queue_load(input int arrival, input int burst, input int prio);
        sched_request_t r;
        r.req     = REQ_LOAD;
        r.arrival = ARR_W'(arrival);
        r.burst   = BURST_W'(burst);
        r.prio    = PRIO_W'(prio);
        pending_requests.push_back(r);
    endtask

    task automatic queue_tick();
        sched_request_t r;
        // load fields are ignored on ticks; fill them with noise
        r.req     = REQ_TICK;
        r.arrival = ARR_W'($urandom);
        r.burst   = BURST_W'($urandom);
        r.prio    = PRIO_W'($urandom);
        pending_requests.push_back(r);
        ticks_queued++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
    endtask

    // driver: present queued requests, predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(schedule_step(cur_req));
                accepted_count++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the current transfer
            end else if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                cur_req   = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.req;
                s_tdata  <= {cur_req.prio, cur_req.burst, cur_req.arrival};
                send_wait = draw_wait(send_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none outstanding, status %0d",
                                              m_tuser[1:0]));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status",          TIME_W'(m_tuser[1:0]),
                                  TIME_W'(want.status));
                    compare_field("finished",        TIME_W'(m_tuser[2]),
                                  TIME_W'(want.finished));
                    compare_field("task_id",         TIME_W'(m_tdata[4:0]),
                                  TIME_W'(want.task_id));
                    compare_field("completion_time", m_tdata[28:5],   want.completion);
                    compare_field("turnaround",      m_tdata[52:29],  want.turnaround);
                    compare_field("waiting",         m_tdata[76:53],  want.waiting);
                    compare_field("now",             m_tdata[100:77], want.now);
                end
                recv_stall = draw_wait(recv_calm);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int arr;
        int prio;

        // idle tick on an empty table
        queue_tick();
        queue_load(0, 0, 0);              // zero burst, never ready
        queue_load(65535, 65535, 0);      // never arrives
        queue_load(0, 3, 255);
        queue_load(0, 1, 255);            // equal priority, higher slot loses
        queue_load(2, 2, 5);              // arrives at tick 2 and preempts
        repeat (4) queue_tick();
        queue_load(0, 1, 0);              // arrival already passed
        repeat (6) queue_tick();          // drain, then idle ticks

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                // mostly arrivals near the current tick, some already past
                arr = ticks_queued + int'($urandom_range(0, 40)) - 10;
                if (arr < 0)
                    arr = 0;
                prio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 7);
                queue_load(arr, $urandom_range(1, 40), prio);
            end else begin
                queue_tick();
            end
        end
        total_items = pending_requests.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < total_items)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
